/* rtl/ccfd_pkg.sv */
// ----------------------------------------------------------------------------
// ccfd_pkg
// shared types, codes and helpers for the command frame decoder
// ----------------------------------------------------------------------------
package ccfd_pkg;

	localparam int VALUE_BITS_DEF = 32;
	localparam int ARG_BITS       = 32;
	localparam int KIND_BITS      = 4;

	localparam logic [7:0] CH_CR    = 8'h0D;
	localparam logic [7:0] CH_CR_SUB = 8'h0E;
	localparam logic [7:0] CH_EQ    = 8'h3D;
	localparam logic [7:0] CH_PLUS  = 8'h2B;
	localparam logic [7:0] CH_MINUS = 8'h2D;
	localparam logic [7:0] CH_ZERO  = 8'h30;
	localparam logic [7:0] CH_NINE  = 8'h39;
	localparam logic [7:0] CH_SPACE = 8'h20;
	localparam logic [7:0] CH_TAB   = 8'h09;

	typedef enum logic [KIND_BITS-1:0] {
		KIND_NONE     = 4'd0,
		KIND_BADSUM   = 4'd1,
		KIND_PING     = 4'd2,
		KIND_RESET    = 4'd3,
		KIND_START_WD = 4'd4,
		KIND_START_NW = 4'd5,
		KIND_KICK_WD  = 4'd6,
		KIND_BATTERY  = 4'd7,
		KIND_VERSION  = 4'd8,
		KIND_MOVE     = 4'd9,
		KIND_TURN     = 4'd10,
		KIND_BUSY     = 4'd11,
		KIND_TEST     = 4'd12,
		KIND_DEBUG    = 4'd13,
		KIND_POWEROFF = 4'd14,
		KIND_SPARE    = 4'd15
	} kind_t;

	typedef enum logic [3:0] {
		PH_SPACE = 4'b0001,
		PH_SIGN  = 4'b0010,
		PH_DIGIT = 4'b0100,
		PH_DONE  = 4'b1000
	} phase_t;

	// classified frame handed from front to back
	typedef struct packed {
		kind_t kind;
		logic  ovf;
		logic  neg;
	} cls_t;

	localparam int CLS_BITS = $bits(cls_t);

	function automatic kind_t map_lead(input logic [7:0] b);
		kind_t k;
		unique case (b)
			8'h70:   k = KIND_PING;     // p
			8'h72:   k = KIND_RESET;    // r
			8'h57:   k = KIND_START_WD; // W
			8'h75:   k = KIND_START_NW; // u
			8'h77:   k = KIND_KICK_WD;  // w
			8'h76:   k = KIND_BATTERY;  // v
			8'h56:   k = KIND_VERSION;  // V
			8'h4D:   k = KIND_MOVE;     // M
			8'h54:   k = KIND_TURN;     // T
			8'h62:   k = KIND_BUSY;     // b
			8'h74:   k = KIND_TEST;     // t
			8'h61:   k = KIND_DEBUG;    // a
			8'h7A:   k = KIND_POWEROFF; // z
			default: k = KIND_NONE;
		endcase
		return k;
	endfunction

	function automatic logic is_space(input logic [7:0] b);
		return (b == CH_SPACE) || ((b >= CH_TAB) && (b <= CH_CR));
	endfunction

	function automatic logic is_digit(input logic [7:0] b);
		return (b >= CH_ZERO) && (b <= CH_NINE);
	endfunction

endpackage

/* rtl/ccfd_front.sv */
// ----------------------------------------------------------------------------
// ccfd_front
// takes frame words, keeps checksum and number parser, classifies on frame end
// ----------------------------------------------------------------------------
module ccfd_front #(
	parameter int VALUE_BITS = ccfd_pkg::VALUE_BITS_DEF
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  take,
	input  logic [7:0]            frame_byte,
	input  logic                  frame_end,
	output logic                  push,
	output ccfd_pkg::cls_t        push_cls,
	output logic [VALUE_BITS-1:0] push_value
);
	import ccfd_pkg::*;

	localparam int WIDE_BITS = VALUE_BITS + 4;

	logic [7:0]            xor_q;
	logic [1:0]            pos_q;
	logic [7:0]            lead_q;
	logic                  eq_q;
	phase_t                phase_q;
	logic                  minus_q;
	logic                  digit_q;
	logic [VALUE_BITS-1:0] value_q;
	logic                  ovf_q;

	logic [7:0]            chk;
	logic [3:0]            dval;
	logic [WIDE_BITS-1:0]  wide_v;
	logic [WIDE_BITS-1:0]  next_wide;
	logic                  is_dig;
	kind_t                 kind;

	assign is_dig    = is_digit(frame_byte);
	assign dval      = frame_byte[3:0];
	assign wide_v    = {4'b0, value_q};
	assign next_wide = (wide_v << 3) + (wide_v << 1) + {{(WIDE_BITS-4){1'b0}}, dval};

	// classification of the checksum word
	always_comb begin
		chk = (xor_q == CH_CR) ? CH_CR_SUB : xor_q;
		if (frame_byte != chk) begin
			kind = KIND_BADSUM;
		end else if (pos_q == 2'd0) begin
			kind = KIND_NONE;
		end else begin
			kind = map_lead(lead_q);
			if ((kind == KIND_MOVE || kind == KIND_TURN) && (!eq_q || !digit_q)) begin
				kind = KIND_NONE;
			end
		end
	end

	assign push          = take && frame_end;
	assign push_cls.kind = kind;
	assign push_cls.ovf  = ovf_q;
	assign push_cls.neg  = minus_q;
	assign push_value    = value_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			xor_q   <= '0;
			pos_q   <= '0;
			lead_q  <= '0;
			eq_q    <= 1'b0;
			phase_q <= PH_SPACE;
			minus_q <= 1'b0;
			digit_q <= 1'b0;
			value_q <= '0;
			ovf_q   <= 1'b0;
		end else if (take && frame_end) begin
			xor_q   <= '0;
			pos_q   <= '0;
			lead_q  <= '0;
			eq_q    <= 1'b0;
			phase_q <= PH_SPACE;
			minus_q <= 1'b0;
			digit_q <= 1'b0;
			value_q <= '0;
			ovf_q   <= 1'b0;
		end else if (take) begin
			xor_q <= xor_q ^ frame_byte;
			if (pos_q != 2'd2) begin
				pos_q <= pos_q + 2'd1;
			end
			if (pos_q == 2'd0) begin
				lead_q <= frame_byte;
			end else if (pos_q == 2'd1) begin
				eq_q <= (frame_byte == CH_EQ);
			end else if (eq_q) begin
				unique case (phase_q)
					PH_SPACE: begin
						if (is_space(frame_byte)) begin
							phase_q <= PH_SPACE;
						end else if (frame_byte == CH_PLUS) begin
							phase_q <= PH_SIGN;
						end else if (frame_byte == CH_MINUS) begin
							minus_q <= 1'b1;
							phase_q <= PH_SIGN;
						end else if (is_dig) begin
							phase_q <= PH_DIGIT;
						end else begin
							phase_q <= PH_DONE;
						end
					end
					PH_SIGN, PH_DIGIT: begin
						phase_q <= is_dig ? PH_DIGIT : PH_DONE;
					end
					PH_DONE: phase_q <= PH_DONE;
					default: phase_q <= PH_DONE;
				endcase
				// digit accumulate, saturating on overflow
				if (is_dig && (phase_q != PH_DONE)) begin
					digit_q <= 1'b1;
					if (!ovf_q) begin
						if (next_wide[WIDE_BITS-1 -: 4] != 4'd0) begin
							ovf_q   <= 1'b1;
							value_q <= '1;
						end else begin
							value_q <= next_wide[VALUE_BITS-1:0];
						end
					end
				end
			end
		end
	end

endmodule

/* rtl/ccfd_queue.sv */
// ----------------------------------------------------------------------------
// ccfd_queue
// two-entry queue between the front and back parts
// ----------------------------------------------------------------------------
module ccfd_queue #(
	parameter int WIDTH = 8
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	input  logic [WIDTH-1:0] push_data,
	input  logic             pop,
	output logic [WIDTH-1:0] pop_data,
	output logic             not_empty,
	output logic             full
);
	localparam int DEPTH = 2;

	logic [WIDTH-1:0] ent_q [DEPTH];
	logic             wr_ptr_q;
	logic             rd_ptr_q;
	logic [1:0]       cnt_q;
	logic             do_pop;

	assign not_empty = (cnt_q != 2'd0);
	assign full      = (cnt_q == 2'd2);
	assign pop_data  = ent_q[rd_ptr_q];
	assign do_pop    = pop && not_empty;

	always_ff @(posedge clk) begin
		if (push) begin
			ent_q[wr_ptr_q] <= push_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			cnt_q    <= 2'd0;
		end else begin
			if (push) begin
				wr_ptr_q <= ~wr_ptr_q;
			end
			if (do_pop) begin
				rd_ptr_q <= ~rd_ptr_q;
			end
			cnt_q <= cnt_q + {1'b0, push} - {1'b0, do_pop};
		end
	end

endmodule

/* rtl/ccfd_back.sv */
// ----------------------------------------------------------------------------
// ccfd_back
// forms the argument from the parsed number and holds the result word
// ----------------------------------------------------------------------------
module ccfd_back #(
	parameter int VALUE_BITS = ccfd_pkg::VALUE_BITS_DEF
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            avail,
	input  ccfd_pkg::cls_t                  cls,
	input  logic [VALUE_BITS-1:0]           value,
	output logic                            pop,
	output logic                            command_valid,
	input  logic                            command_stall,
	output logic [ccfd_pkg::KIND_BITS-1:0]  command_kind,
	output logic [ccfd_pkg::ARG_BITS-1:0]   argument_value
);
	import ccfd_pkg::*;

	logic                  valid_q;
	logic [KIND_BITS-1:0]  kind_q;
	logic [ARG_BITS-1:0]   arg_q;
	logic [VALUE_BITS-1:0] full_arg;
	logic [ARG_BITS-1:0]   arg32;
	logic                  has_arg;

	assign has_arg  = (cls.kind == KIND_MOVE) || (cls.kind == KIND_TURN);
	assign full_arg = cls.ovf ? '1 : (cls.neg ? ('0 - value) : value);

	generate
		if (VALUE_BITS >= ARG_BITS) begin : g_trunc
			assign arg32 = full_arg[ARG_BITS-1:0];
		end else begin : g_ext
			assign arg32 = {{(ARG_BITS-VALUE_BITS){1'b0}}, full_arg};
		end
	endgenerate

	assign pop            = avail && (!valid_q || !command_stall);
	assign command_valid  = valid_q;
	assign command_kind   = kind_q;
	assign argument_value = arg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (!valid_q || !command_stall) begin
			valid_q <= avail;
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			kind_q <= cls.kind;
			arg_q  <= has_arg ? arg32 : '0;
		end
	end

endmodule

/* rtl/checksummed_command_frame_decoder.sv */
// ----------------------------------------------------------------------------
// checksummed_command_frame_decoder
// checksummed command frame decoder; unless stalled, one frame word per cycle
// ----------------------------------------------------------------------------
// latency: accepted checksum word -> queue entry -> result register
// throughput: unless stalled, one frame word per cycle, single parser stage
// the two-entry queue stalls the frame side only when the result side stalls
// reset: asynchronous, clears parser state, queue and result valid
// ----------------------------------------------------------------------------
module checksummed_command_frame_decoder #(
	parameter int VALUE_BITS = ccfd_pkg::VALUE_BITS_DEF
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           frame_valid,
	output logic                           frame_stall,
	input  logic [7:0]                     frame_byte,
	input  logic                           frame_end,
	output logic                           command_valid,
	input  logic                           command_stall,
	output logic [ccfd_pkg::KIND_BITS-1:0] command_kind,
	output logic [ccfd_pkg::ARG_BITS-1:0]  argument_value
);
	import ccfd_pkg::*;

	localparam int Q_BITS = CLS_BITS + VALUE_BITS;

	logic                  take;
	logic                  push;
	cls_t                  push_cls;
	logic [VALUE_BITS-1:0] push_value;
	logic [Q_BITS-1:0]     q_out;
	logic                  q_avail;
	logic                  q_full;
	logic                  pop;
	cls_t                  pop_cls;
	logic [VALUE_BITS-1:0] pop_value;

	assign frame_stall = q_full;
	assign take        = frame_valid && !q_full;

	ccfd_front #(
		.VALUE_BITS(VALUE_BITS)
	) u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.take       (take),
		.frame_byte (frame_byte),
		.frame_end  (frame_end),
		.push       (push),
		.push_cls   (push_cls),
		.push_value (push_value)
	);

	ccfd_queue #(
		.WIDTH(Q_BITS)
	) u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_data ({push_cls, push_value}),
		.pop       (pop),
		.pop_data  (q_out),
		.not_empty (q_avail),
		.full      (q_full)
	);

	assign pop_cls   = q_out[Q_BITS-1 -: CLS_BITS];
	assign pop_value = q_out[VALUE_BITS-1:0];

	ccfd_back #(
		.VALUE_BITS(VALUE_BITS)
	) u_back (
		.clk            (clk),
		.arst_n         (arst_n),
		.avail          (q_avail),
		.cls            (pop_cls),
		.value          (pop_value),
		.pop            (pop),
		.command_valid  (command_valid),
		.command_stall  (command_stall),
		.command_kind   (command_kind),
		.argument_value (argument_value)
	);

endmodule

/* tb/ccfd_checker.sv */
// ----------------------------------------------------------------------------
// ccfd_checker
// watches both channels of the command frame decoder, works out the command
// word that each accepted checksum word must produce and compares it, field by
// field, with the oldest one outstanding
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module ccfd_checker (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           frame_valid,
	input  logic                           frame_stall,
	input  logic [7:0]                     frame_byte,
	input  logic                           frame_end,
	input  logic                           command_valid,
	input  logic                           command_stall,
	input  logic [ccfd_pkg::KIND_BITS-1:0] command_kind,
	input  logic [ccfd_pkg::ARG_BITS-1:0]  argument_value,
	output int                             fail_count,
	output int                             pending,
	output int                             compared,
	output logic [15:0]                    kinds_seen
);
	import ccfd_pkg::*;

	typedef struct packed {
		kind_t       kind;
		logic [31:0] arg;
	} command_t;

	command_t    command_q[$];

	// running frame state
	logic [7:0]  xor_acc;
	logic [7:0]  lead;
	logic        any_payload;
	int unsigned payload_pos;
	logic        eq_ok;
	phase_t      num_phase;
	logic        neg;
	logic        got_digit;
	logic        ovf;
	logic [31:0] value;

	task automatic clear_frame();
		xor_acc     = '0;
		lead        = '0;
		any_payload = 1'b0;
		payload_pos = 0;
		eq_ok       = 1'b0;
		num_phase   = PH_SPACE;
		neg         = 1'b0;
		got_digit   = 1'b0;
		ovf         = 1'b0;
		value       = '0;
	endtask

	task automatic add_digit(input logic [7:0] b);
		logic [63:0] wide;
		got_digit = 1'b1;
		if (!ovf) begin
			wide = 64'(value) * 64'd10 + 64'(b - CH_ZERO);
			if (wide > 64'hFFFF_FFFF) begin
				ovf   = 1'b1;
				value = '1;
			end else begin
				value = wide[31:0];
			end
		end
	endtask

	task automatic parse_number(input logic [7:0] b);
		logic dig;
		dig = (b >= CH_ZERO) && (b <= CH_NINE);
		case (num_phase)
			PH_SPACE: begin
				if (b == CH_SPACE || (b >= CH_TAB && b <= CH_CR)) begin
				end else if (b == CH_PLUS) begin
					num_phase = PH_SIGN;
				end else if (b == CH_MINUS) begin
					neg       = 1'b1;
					num_phase = PH_SIGN;
				end else if (dig) begin
					add_digit(b);
					num_phase = PH_DIGIT;
				end else begin
					num_phase = PH_DONE;
				end
			end
			PH_SIGN, PH_DIGIT: begin
				if (dig) begin
					add_digit(b);
					num_phase = PH_DIGIT;
				end else begin
					num_phase = PH_DONE;
				end
			end
			default: begin
			end
		endcase
	endtask

	function automatic kind_t lead_kind(input logic [7:0] b);
		case (b)
			"p":     return KIND_PING;
			"r":     return KIND_RESET;
			"W":     return KIND_START_WD;
			"u":     return KIND_START_NW;
			"w":     return KIND_KICK_WD;
			"v":     return KIND_BATTERY;
			"V":     return KIND_VERSION;
			"M":     return KIND_MOVE;
			"T":     return KIND_TURN;
			"b":     return KIND_BUSY;
			"t":     return KIND_TEST;
			"a":     return KIND_DEBUG;
			"z":     return KIND_POWEROFF;
			default: return KIND_NONE;
		endcase
	endfunction

	function automatic command_t decode_command(input logic [7:0] chk_byte);
		command_t    c;
		logic [7:0]  chk;
		chk   = (xor_acc == CH_CR) ? CH_CR_SUB : xor_acc;
		c.arg = '0;
		if (chk_byte != chk) begin
			c.kind = KIND_BADSUM;
		end else if (!any_payload) begin
			c.kind = KIND_NONE;
		end else begin
			c.kind = lead_kind(lead);
			if (c.kind == KIND_MOVE || c.kind == KIND_TURN) begin
				if (!eq_ok || !got_digit)
					c.kind = KIND_NONE;
				else if (ovf)
					c.arg = '1;
				else if (neg)
					c.arg = -value;
				else
					c.arg = value;
			end
		end
		return c;
	endfunction

	always @(posedge clk or negedge arst_n) begin : watch
		command_t c;
		int       errs;
		if (!arst_n) begin
			clear_frame();
			command_q.delete();
			fail_count <= 0;
			pending    <= 0;
			compared   <= 0;
			kinds_seen <= '0;
		end else begin
			errs = 0;
			if (frame_valid && !frame_stall) begin
				if (!frame_end) begin
					if (payload_pos == 0)
						lead = frame_byte;
					else if (payload_pos == 1)
						eq_ok = (frame_byte == CH_EQ);
					else if (eq_ok)
						parse_number(frame_byte);
					xor_acc     = xor_acc ^ frame_byte;
					any_payload = 1'b1;
					if (payload_pos < 2)
						payload_pos++;
				end else begin
					command_q.push_back(decode_command(frame_byte));
					clear_frame();
				end
			end
			if (command_valid && !command_stall) begin
				if (command_q.size() == 0) begin
					$error("command word with nothing expected: kind %0d, argument %0d",
						command_kind, argument_value);
					errs++;
				end else begin
					c = command_q.pop_front();
					if (command_kind !== c.kind) begin
						$error("command_kind: expected %0d, actual %0d", c.kind, command_kind);
						errs++;
					end
					if (argument_value !== c.arg) begin
						$error("argument_value: expected %0d, actual %0d", c.arg,
							argument_value);
						errs++;
					end
					kinds_seen[c.kind] <= 1'b1;
					compared <= compared + 1;
				end
			end
			fail_count <= fail_count + errs;
			pending <= command_q.size();
		end
	end

endmodule

/* tb/testbench.sv */
// ----------------------------------------------------------------------------
// testbench
// drives command frames into the decoder: a directed set covering every
// command letter, number forms, checksum substitution and bad checksums,
// then random frames under three idling mixes; results go to the checker
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module testbench;
	import ccfd_pkg::*;

	localparam int WORDS_PER_MIX = 517;
	localparam int WATCHDOG      = 4000;

	localparam int SUM_GOOD    = 0;
	localparam int SUM_CORRUPT = 1;
	localparam int SUM_RAW     = 2;

	logic                 clk = 1'b0;
	logic                 arst_n = 1'b0;
	logic                 frame_valid = 1'b0;
	logic                 frame_stall;
	logic [7:0]           frame_byte = '0;
	logic                 frame_end = 1'b0;
	logic                 command_valid;
	logic                 command_stall = 1'b0;
	logic [KIND_BITS-1:0] command_kind;
	logic [ARG_BITS-1:0]  argument_value;

	int                   fail_count;
	int                   pending;
	int                   compared;
	logic [15:0]          kinds_seen;

	int                   send_idle_pct = 0;
	int                   stall_pct = 0;
	int                   word_count = 0;
	int                   frame_count = 0;
	int                   quiet_cycles = 0;

	logic [7:0]           frame_q[$];
	logic [7:0]           lead_codes[13] = '{"p", "r", "W", "u", "w", "v", "V", "M", "T",
		"b", "t", "a", "z"};

	always #1 clk = ~clk;

	checksummed_command_frame_decoder dut (
		.clk            (clk),
		.arst_n         (arst_n),
		.frame_valid    (frame_valid),
		.frame_stall    (frame_stall),
		.frame_byte     (frame_byte),
		.frame_end      (frame_end),
		.command_valid  (command_valid),
		.command_stall  (command_stall),
		.command_kind   (command_kind),
		.argument_value (argument_value)
	);

	ccfd_checker u_checker (
		.clk            (clk),
		.arst_n         (arst_n),
		.frame_valid    (frame_valid),
		.frame_stall    (frame_stall),
		.frame_byte     (frame_byte),
		.frame_end      (frame_end),
		.command_valid  (command_valid),
		.command_stall  (command_stall),
		.command_kind   (command_kind),
		.argument_value (argument_value),
		.fail_count     (fail_count),
		.pending        (pending),
		.compared       (compared),
		.kinds_seen     (kinds_seen)
	);

	always @(posedge clk) begin
		command_stall <= ($urandom_range(99) < stall_pct);
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if ((frame_valid && !frame_stall) || (command_valid && !command_stall))
				quiet_cycles <= 0;
			else
				quiet_cycles <= quiet_cycles + 1;
			if (quiet_cycles == WATCHDOG) begin
				$display("timeout: no word moved for %0d cycles", WATCHDOG);
				$display("testbench: FAIL");
				$finish;
			end
		end
	end

	task automatic send_word(input logic [7:0] b, input logic e);
		while ($urandom_range(99) < send_idle_pct) begin
			frame_valid <= 1'b0;
			frame_byte  <= $urandom;
			frame_end   <= $urandom;
			@(posedge clk);
		end
		frame_valid <= 1'b1;
		frame_byte  <= b;
		frame_end   <= e;
		do
			@(posedge clk);
		while (frame_stall);
		word_count++;
	endtask

	task automatic send_frame(input int mode);
		logic [7:0] chk;
		chk = '0;
		foreach (frame_q[i]) begin
			chk ^= frame_q[i];
			send_word(frame_q[i], 1'b0);
		end
		if (mode != SUM_RAW && chk == CH_CR)
			chk = CH_CR_SUB;
		if (mode == SUM_CORRUPT)
			chk ^= 8'($urandom_range(1, 255));
		send_word(chk, 1'b1);
		frame_count++;
		frame_q.delete();
	endtask

	task automatic text_frame(input string s, input int mode);
		for (int i = 0; i < s.len(); i++)
			frame_q.push_back(s[i]);
		send_frame(mode);
	endtask

	task automatic add_number();
		int n_digits;
		int sel;
		repeat (($urandom_range(3) == 0) ? $urandom_range(1, 3) : 0)
			frame_q.push_back(($urandom_range(1) == 0) ? CH_SPACE
				: 8'($urandom_range(CH_TAB, CH_CR)));
		sel = $urandom_range(5);
		if (sel == 0)
			frame_q.push_back(CH_PLUS);
		else if (sel == 1)
			frame_q.push_back(CH_MINUS);
		sel = $urandom_range(9);
		if (sel == 0)
			n_digits = 0;
		else if (sel <= 2)
			n_digits = 10;
		else if (sel == 3)
			n_digits = $urandom_range(11, 12);
		else
			n_digits = $urandom_range(1, 9);
		for (int i = 0; i < n_digits; i++) begin
			// ten-digit numbers hover around the 32-bit limit
			if (i == 0 && n_digits == 10)
				frame_q.push_back(CH_ZERO + 8'($urandom_range(3, 5)));
			else
				frame_q.push_back(CH_ZERO + 8'($urandom_range(9)));
		end
	endtask

	task automatic random_frame();
		int sel;
		sel = $urandom_range(99);
		if (sel < 75) begin
			sel = $urandom_range(99);
			if (sel < 45) begin
				frame_q.push_back(($urandom_range(1) == 0) ? 8'("M") : 8'("T"));
				frame_q.push_back(($urandom_range(9) == 0) ? 8'($urandom) : CH_EQ);
				add_number();
			end else if (sel < 92) begin
				frame_q.push_back(lead_codes[$urandom_range(12)]);
			end else begin
				frame_q.push_back(8'($urandom));
			end
			repeat (($urandom_range(3) == 0) ? $urandom_range(1, 3) : 0)
				frame_q.push_back(8'($urandom));
		end else begin
			repeat ($urandom_range(6))
				frame_q.push_back(8'($urandom));
		end
		send_frame(($urandom_range(99) < 85) ? SUM_GOOD : SUM_CORRUPT);
	endtask

	task automatic directed_frames();
		text_frame("", SUM_GOOD);
		text_frame("", SUM_CORRUPT);
		foreach (lead_codes[i])
			text_frame(string'(lead_codes[i]), SUM_GOOD);
		text_frame("x", SUM_GOOD);
		text_frame("M=123", SUM_GOOD);
		text_frame("T=-45", SUM_GOOD);
		text_frame("M= \t\n\r+7", SUM_GOOD);
		text_frame("M=4294967295", SUM_GOOD);
		text_frame("T=4294967296", SUM_GOOD);
		text_frame("T=-4294967295", SUM_GOOD);
		text_frame("M=-99999999999", SUM_GOOD);
		text_frame("M=", SUM_GOOD);
		text_frame("T=+", SUM_GOOD);
		text_frame("M=--5", SUM_GOOD);
		text_frame("M 12", SUM_GOOD);
		text_frame("T=12x34", SUM_GOOD);
		text_frame("M=12", SUM_CORRUPT);
		// payload xor lands on CR, so the sent checksum must be substituted
		text_frame("p}", SUM_GOOD);
		text_frame("p}", SUM_RAW);
		frame_q = '{"M", CH_EQ, 8'h00, "5"};
		send_frame(SUM_GOOD);
		frame_q = '{8'h00, 8'hFF};
		send_frame(SUM_GOOD);
	endtask

	initial begin
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		for (int mix = 0; mix < 3; mix++) begin
			case (mix)
				0: begin
					send_idle_pct = 16;
					stall_pct     = 51;
				end
				1: begin
					send_idle_pct = 51;
					stall_pct     = 16;
				end
				default: begin
					send_idle_pct = 0;
					stall_pct     = 0;
				end
			endcase
			if (mix == 0)
				directed_frames();
			while (word_count < WORDS_PER_MIX * (mix + 1))
				random_frame();
		end
		frame_valid <= 1'b0;
		@(posedge clk);
		while (pending != 0)
			@(posedge clk);
		repeat (16) @(posedge clk);
		$display("covered %0d frame words in %0d frames under three idling mixes",
			word_count, frame_count);
		$display("%0d command words compared, %0d distinct command kinds returned",
			compared, $countones(kinds_seen));
		if (fail_count == 0)
			$display("testbench: PASS");
		else
			$display("testbench: FAIL");
		$finish;
	end

endmodule
